// ===== rtl/core/sudm_pkg.sv =====
`default_nettype none
package sudm_pkg;

    // default sizes
    localparam int COUNT_BITS_DEF   = 20;
    localparam int FRAC_BITS_DEF    = 32;
    localparam int GUARD_BITS       = 8;
    localparam int RUN_LENGTH_RESET = 1024;

    // register byte addresses
    localparam int RUN_LENGTH_ADDR  = 0;

    // log constant table
    localparam int TAB_DEPTH = 64;
    localparam int TAB_IDX_W = 6;

    // width of the exp scaling exponent k
    localparam int K_W = 7;

    typedef logic [63:0] ln_tab_t [TAB_DEPTH];

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_NORM,
        BK_LOG,
        BK_LROUND,
        BK_DIV,
        BK_EXPK,
        BK_EXPR,
        BK_SCALE,
        BK_MUL,
        BK_ROUND,
        BK_DONE
    } back_state_t;

    // long division for table construction
    function automatic longint unsigned div_floor(input longint unsigned a,
                                                  input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        int i;
        q = 64'd0;
        r = 64'd0;
        for (i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // c_j = -ln(1 - 2^-j) as a series at 62 bits, rounded to w bits
    function automatic ln_tab_t ln_table(input int w);
        ln_tab_t t;
        longint unsigned s;
        int j;
        int n;
        for (j = 0; j < TAB_DEPTH; j++) begin
            t[j] = 64'd0;
        end
        for (j = 1; j <= w; j++) begin
            s = 64'd0;
            for (n = 1; j * n <= 62; n++) begin
                s += div_floor(64'd1 << (62 - j * n), 64'(n));
            end
            t[j] = (s + (64'd1 << (61 - w))) >> (62 - w);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sudm_queue.sv =====
`default_nettype none
module sudm_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // two-entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sudm_front.sv =====
`default_nettype none
module sudm_front #(
    parameter int COUNT_BITS = sudm_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = sudm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [31:0]                   s_uniform_sample,
    input  wire logic [COUNT_BITS:0]           run_length,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [FRAC_BITS+COUNT_BITS+1:0]    q_data
);

    localparam int F   = FRAC_BITS;
    localparam int I_W = COUNT_BITS + 1;
    localparam logic [I_W-1:0] RUN_MAX = I_W'(1) << COUNT_BITS;

    logic [I_W-1:0]  cnt_reg;
    logic [I_W-1:0]  cnt_next;
    logic [I_W-1:0]  run_n;
    logic [I_W-1:0]  idx;
    logic [F+31:0]   u_wide;
    logic [F-1:0]    uf;
    logic [F:0]      v;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // run length with zero and overflow clamped
    always_comb begin
        if (run_length == '0) begin
            run_n = I_W'(1);
        end else if (run_length > RUN_MAX) begin
            run_n = RUN_MAX;
        end else begin
            run_n = run_length;
        end
    end

    // index of this beat, reload at run start
    assign idx      = (cnt_reg == '0) ? run_n : cnt_reg;
    assign cnt_next = idx - I_W'(1);

    // sample to F fraction bits, then 1 - u
    assign u_wide = {s_uniform_sample, F'(0)};
    assign uf     = u_wide[F+31:32];
    assign v      = {1'b1, F'(0)} - {1'b0, uf};

    assign q_data = {v, idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (q_push) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sudm_back.sv =====
`default_nettype none
module sudm_back #(
    parameter int COUNT_BITS = sudm_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = sudm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_empty,
    output logic                               q_pop,
    input  wire logic [FRAC_BITS+COUNT_BITS+1:0] q_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [FRAC_BITS:0]                 m_sorted_value,
    output logic [COUNT_BITS-1:0]              m_position,
    output logic                               m_last_of_run
);

    localparam int F     = FRAC_BITS;
    localparam int G     = sudm_pkg::GUARD_BITS;
    localparam int W     = F + G;
    localparam int I_W   = COUNT_BITS + 1;
    localparam int ACC_W = W + 7;
    localparam int L_W   = ACC_W - G;
    localparam int QW_W  = L_W + G;
    localparam int DB_W  = $clog2(L_W);
    localparam int H     = (F + 2) / 2;
    localparam int P_W   = 2 * F + 2;
    localparam int J_W   = sudm_pkg::TAB_IDX_W;
    localparam int K_W   = sudm_pkg::K_W;

    localparam sudm_pkg::ln_tab_t LN_TAB = sudm_pkg::ln_table(W);
    localparam logic [W-1:0] C1    = LN_TAB[1][W-1:0];
    localparam logic [W:0]   ONE_W = (W+1)'(1) << W;
    localparam logic [F:0]   ONE_F = (F+1)'(1) << F;

    sudm_pkg::back_state_t state_reg, state_next;

    logic [W:0]       w_reg;
    logic [W:0]       y_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [J_W-1:0]   j_reg;
    logic [I_W-1:0]   i_reg;
    logic [L_W-1:0]   div_reg;
    logic [I_W:0]     rem_reg;
    logic [DB_W-1:0]  bit_reg;
    logic [QW_W-1:0]  qw_reg;
    logic [K_W-1:0]   k_reg;
    logic [F:0]       e_reg;
    logic [P_W-1:0]   prod_reg;
    logic [1:0]       pp_reg;
    logic [F:0]       val_reg;
    logic [F:0]       run_max_reg;
    logic             out_valid_reg;
    logic [F:0]       out_value_reg;
    logic [COUNT_BITS-1:0] out_pos_reg;
    logic             out_last_reg;

    logic             load_out;
    logic [W:0]       y_step;
    logic [W-1:0]     c_j;
    logic [ACC_W-1:0] acc_rnd;
    logic [I_W:0]     rem_sh;
    logic             div_ge;
    logic [L_W-1:0]   div_next;
    logic [7:0]       sh;
    logic [W+1:0]     y_rnd;
    logic [W+1:0]     e_full;
    logic [H-1:0]     pa;
    logic [H-1:0]     pb;
    logic [2*H-1:0]   pmul;
    logic [P_W-1:0]   pprod;
    logic [P_W-1:0]   pp_shift;
    logic [P_W-1:0]   p_rnd;
    logic [F+1:0]     val_full;
    logic [F:0]       job_v;
    logic [I_W-1:0]   job_i;
    logic [W:0]       w_init;

    assign job_v  = q_data[F+I_W:I_W];
    assign job_i  = q_data[I_W-1:0];
    assign w_init = {job_v, G'(0)};

    // shared shift-subtract step and table read
    assign y_step  = y_reg - (y_reg >> j_reg);
    assign c_j     = LN_TAB[j_reg][W-1:0];
    assign acc_rnd = acc_reg + ACC_W'(1 << (G - 1));

    // restoring divide step
    assign rem_sh   = {rem_reg[I_W-1:0], div_reg[L_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, i_reg});
    assign div_next = {div_reg[L_W-2:0], div_ge};

    // exp scaling by 2^-k with rounding
    assign sh     = 8'(k_reg) + 8'(G);
    assign y_rnd  = {1'b0, y_reg} + ((W+2)'(1) << (sh - 8'd1));
    assign e_full = y_rnd >> sh;

    // one partial product per cycle
    always_comb begin
        pa = pp_reg[0] ? H'(run_max_reg[F:H]) : run_max_reg[H-1:0];
        pb = pp_reg[1] ? H'(e_reg[F:H]) : e_reg[H-1:0];
    end
    assign pmul  = pa * pb;
    assign pprod = P_W'(pmul);
    always_comb begin
        case (pp_reg)
            2'd0:    pp_shift = pprod;
            2'd3:    pp_shift = pprod << (2 * H);
            default: pp_shift = pprod << H;
        endcase
    end
    assign p_rnd    = prod_reg + (P_W'(1) << (F - 1));
    assign val_full = p_rnd[2*F+1:F];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sudm_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    if (w_init >= ONE_W || w_init == '0) begin
                        state_next = sudm_pkg::BK_DIV;
                    end else begin
                        state_next = sudm_pkg::BK_NORM;
                    end
                end
            end
            sudm_pkg::BK_NORM: begin
                if (w_reg[W-1]) begin
                    state_next = sudm_pkg::BK_LOG;
                end
            end
            sudm_pkg::BK_LOG: begin
                if (j_reg == J_W'(W)) begin
                    state_next = sudm_pkg::BK_LROUND;
                end
            end
            sudm_pkg::BK_LROUND: state_next = sudm_pkg::BK_DIV;
            sudm_pkg::BK_DIV: begin
                if (bit_reg == '0) begin
                    state_next = sudm_pkg::BK_EXPK;
                end
            end
            sudm_pkg::BK_EXPK: begin
                if (qw_reg < QW_W'(C1)) begin
                    state_next = sudm_pkg::BK_EXPR;
                end
            end
            sudm_pkg::BK_EXPR: begin
                if (j_reg == J_W'(W)) begin
                    state_next = sudm_pkg::BK_SCALE;
                end
            end
            sudm_pkg::BK_SCALE: state_next = sudm_pkg::BK_MUL;
            sudm_pkg::BK_MUL: begin
                if (pp_reg == 2'd3) begin
                    state_next = sudm_pkg::BK_ROUND;
                end
            end
            sudm_pkg::BK_ROUND: state_next = sudm_pkg::BK_DONE;
            sudm_pkg::BK_DONE: begin
                if (load_out) begin
                    state_next = sudm_pkg::BK_IDLE;
                end
            end
            default: state_next = sudm_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            sudm_pkg::BK_IDLE: q_pop    = !q_empty;
            sudm_pkg::BK_DONE: load_out = !out_valid_reg || m_ready;
            default: begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sudm_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            run_max_reg   <= ONE_F;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
                run_max_reg   <= (i_reg == I_W'(1)) ? ONE_F : val_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            sudm_pkg::BK_IDLE: begin
                w_reg   <= w_init;
                y_reg   <= ONE_W;
                acc_reg <= '0;
                j_reg   <= J_W'(1);
                i_reg   <= job_i;
                div_reg <= '0;
                rem_reg <= '0;
                bit_reg <= DB_W'(L_W - 1);
            end
            sudm_pkg::BK_NORM: begin
                if (!w_reg[W-1]) begin
                    w_reg   <= w_reg << 1;
                    acc_reg <= acc_reg + ACC_W'(C1);
                end
            end
            sudm_pkg::BK_LOG: begin
                if (y_step >= w_reg) begin
                    y_reg   <= y_step;
                    acc_reg <= acc_reg + ACC_W'(c_j);
                end
                j_reg <= j_reg + J_W'(1);
            end
            sudm_pkg::BK_LROUND: begin
                div_reg <= acc_rnd[ACC_W-1:G];
                rem_reg <= '0;
                bit_reg <= DB_W'(L_W - 1);
            end
            sudm_pkg::BK_DIV: begin
                rem_reg <= div_ge ? (rem_sh - {1'b0, i_reg}) : rem_sh;
                div_reg <= div_next;
                bit_reg <= bit_reg - DB_W'(1);
                qw_reg  <= {div_next, G'(0)};
                k_reg   <= '0;
            end
            sudm_pkg::BK_EXPK: begin
                if (qw_reg >= QW_W'(C1)) begin
                    qw_reg <= qw_reg - QW_W'(C1);
                    k_reg  <= k_reg + K_W'(1);
                end
                y_reg <= ONE_W;
                j_reg <= J_W'(2);
            end
            sudm_pkg::BK_EXPR: begin
                if (qw_reg >= QW_W'(c_j)) begin
                    qw_reg <= qw_reg - QW_W'(c_j);
                    y_reg  <= y_step;
                end
                j_reg <= j_reg + J_W'(1);
            end
            sudm_pkg::BK_SCALE: begin
                e_reg    <= (sh >= 8'(W + 2)) ? '0 : e_full[F:0];
                prod_reg <= '0;
                pp_reg   <= 2'd0;
            end
            sudm_pkg::BK_MUL: begin
                prod_reg <= prod_reg + pp_shift;
                pp_reg   <= pp_reg + 2'd1;
            end
            sudm_pkg::BK_ROUND: begin
                val_reg <= (val_full > (F+2)'(ONE_F)) ? ONE_F : val_full[F:0];
            end
            sudm_pkg::BK_DONE: begin
                if (load_out) begin
                    out_value_reg <= val_reg;
                    out_pos_reg   <= COUNT_BITS'(i_reg - I_W'(1));
                    out_last_reg  <= (i_reg == I_W'(1));
                end
            end
            default: begin
                w_reg <= w_reg;
            end
        endcase
    end

    assign m_valid        = out_valid_reg;
    assign m_sorted_value = out_value_reg;
    assign m_position     = out_pos_reg;
    assign m_last_of_run  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sorted_uniform_descending_max_core.sv =====
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// sample   | s_valid s_ready s_uniform_sample        | in
// result   | m_valid m_ready m_sorted_value          | out
//          | m_position m_last_of_run                |
// config   | psel penable pwrite paddr pwdata prdata | in/out
//
// a beat in the back engine runs the normalizing shifts, the log steps, the restoring
// divide, the ln 2 reductions of the quotient, the exp steps, the scaling and the
// partial-product multiply; a zero sample skips the normalizing and the log.
// reset is synchronous active-low; no clearing pass, the block accepts right after reset.
// the front takes samples into a two-entry queue while the back engine works;
// a stalled result holds in the output register and the engine waits only then.
`default_nettype none
module sorted_uniform_descending_max_core #(
    parameter int COUNT_BITS = sudm_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = sudm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [31:0]                           s_uniform_sample,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [FRAC_BITS:0]                         m_sorted_value,
    output logic [COUNT_BITS-1:0]                      m_position,
    output logic                                       m_last_of_run,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [((COUNT_BITS + 1 > 32) ? 3 : 2)-1:0] paddr,
    input  wire logic [((COUNT_BITS + 1 > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COUNT_BITS + 1 > 32) ? 64 : 32)-1:0] prdata,
    output logic                                       pready
);

    localparam int RL_W   = COUNT_BITS + 1;
    localparam int DATA_W = (RL_W > 32) ? 64 : 32;
    localparam int ADDR_W = (RL_W > 32) ? 3 : 2;
    localparam int JOB_W  = FRAC_BITS + COUNT_BITS + 2;

    logic [RL_W-1:0]  run_length_reg;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    logic [JOB_W-1:0] q_in;
    logic [JOB_W-1:0] q_out;
    logic             cfg_write;

    // config register, the only one sits at offset zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr == ADDR_W'(sudm_pkg::RUN_LENGTH_ADDR));
    assign prdata    = DATA_W'(run_length_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_length_reg <= RL_W'(sudm_pkg::RUN_LENGTH_RESET);
        end else if (cfg_write) begin
            run_length_reg <= pwdata[RL_W-1:0];
        end
    end

    sudm_front #(
        .COUNT_BITS(COUNT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_uniform_sample(s_uniform_sample),
        .run_length      (run_length_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_in)
    );

    sudm_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .pop      (q_pop),
        .pop_data (q_out),
        .full     (q_full),
        .empty    (q_empty)
    );

    sudm_back #(
        .COUNT_BITS(COUNT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_data        (q_out),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_position    (m_position),
        .m_last_of_run (m_last_of_run)
    );

endmodule
`default_nettype wire

// ===== bench/sorted_uniform_descending_max_checker.sv =====
`default_nettype none
module sorted_uniform_descending_max_checker #(
    parameter logic [1:0] RUN_LENGTH_ADDR = 2'd0
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [31:0] s_uniform_sample,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [32:0] m_sorted_value,
    input  wire logic [19:0] m_position,
    input  wire logic        m_last_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int F = 32;
    localparam int G = 8;
    localparam int W = F + G;
    localparam longint unsigned ONE_F = 64'd1 << F;
    localparam longint unsigned ONE_W = 64'd1 << W;
    localparam longint unsigned RUN_CAP = 64'd1 << 20;

    typedef struct packed {
        logic [32:0] sorted_value;
        logic [19:0] position;
        logic        last_of_run;
    } sorted_beat_t;

    longint unsigned ln_const [64];
    longint unsigned run_length;
    longint unsigned running_max;
    longint unsigned remaining;
    sorted_beat_t    expected_beats [$];

    // -ln(1 - 2^-j) series constants, rounded to the work width
    initial begin
        longint unsigned acc;
        for (int j = 0; j < 64; j++) ln_const[j] = 64'd0;
        for (int j = 1; j <= W; j++) begin
            acc = 64'd0;
            for (int n = 1; j * n <= 62; n++) acc += (64'd1 << (62 - j * n)) / n;
            ln_const[j] = (acc + (64'd1 << (61 - W))) >> (62 - W);
        end
    end

    // magnitude of ln(v), v in (0,1] at F bits
    function automatic longint unsigned log_magnitude(longint unsigned v);
        longint unsigned w, y, acc, s, d;
        w = v << G;
        y = ONE_W;
        acc = 0;
        s = 0;
        if (w >= ONE_W || w == 0) return 64'd0;
        while (w < (ONE_W >> 1)) begin
            w = w << 1;
            s++;
        end
        for (int j = 1; j <= W; j++) begin
            d = y - (y >> j);
            if (d >= w) begin
                y = d;
                acc += ln_const[j];
            end
        end
        acc += s * ln_const[1];
        return (acc + (64'd1 << (G - 1))) >> G;
    endfunction

    // exp(-q) as Q1.F, rounded
    function automatic longint unsigned exp_of_negative(longint unsigned q);
        longint unsigned qw, k, r, y, sh;
        qw = q << G;
        k = qw / ln_const[1];
        r = qw - k * ln_const[1];
        y = ONE_W;
        for (int j = 2; j <= W; j++) begin
            if (r >= ln_const[j]) begin
                r -= ln_const[j];
                y -= y >> j;
            end
        end
        sh = k + G;
        if (sh > 63) return 64'd0;
        return (y + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // next sorted value, advances the run state
    function automatic sorted_beat_t next_sorted(logic [31:0] u);
        sorted_beat_t b;
        longint unsigned n, i, q, e, val;
        logic [127:0] prod;
        if (remaining == 0) begin
            n = run_length;
            if (n == 0) n = 1;
            if (n > RUN_CAP) n = RUN_CAP;
            remaining = n;
        end
        i = remaining;
        q = log_magnitude(ONE_F - {32'd0, u}) / i;
        e = exp_of_negative(q);
        prod = {64'd0, running_max} * {64'd0, e};
        prod = prod + (128'd1 << (F - 1));
        val = prod[F +: 64];
        if (val > ONE_F) val = ONE_F;
        b.sorted_value = val[32:0];
        b.position = i[19:0] - 20'd1;
        b.last_of_run = (i == 1);
        remaining = i - 1;
        running_max = (i == 1) ? ONE_F : val;
        return b;
    endfunction

    // watch config, sample and result beats
    always @(posedge aclk) begin
        sorted_beat_t want;
        if (!aresetn) begin
            run_length  = 1024;
            running_max = ONE_F;
            remaining   = 0;
            expected_beats.delete();
            fail_count  = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == RUN_LENGTH_ADDR)
                run_length = {43'd0, pwdata[20:0]};
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (m_sorted_value !== want.sorted_value) begin
                        $error("sorted_value expected %h actual %h",
                               want.sorted_value, m_sorted_value);
                        fail_count++;
                    end
                    if (m_position !== want.position) begin
                        $error("position expected %0d actual %0d",
                               want.position, m_position);
                        fail_count++;
                    end
                    if (m_last_of_run !== want.last_of_run) begin
                        $error("last_of_run expected %b actual %b",
                               want.last_of_run, m_last_of_run);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_beats.push_back(next_sorted(s_uniform_sample));
        end
        pending = expected_beats.size();
    end

endmodule
`default_nettype wire

// ===== bench/sorted_uniform_descending_max_core_test.sv =====
`default_nettype none
module sorted_uniform_descending_max_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] RUN_LENGTH_ADDR = 2'd0;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_uniform_sample = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [32:0] m_sorted_value;
    logic [19:0] m_position;
    logic        m_last_of_run;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          no_idle = 1'b0;

    sorted_uniform_descending_max_core dut (.*);

    sorted_uniform_descending_max_checker #(.RUN_LENGTH_ADDR(RUN_LENGTH_ADDR)) u_checker (.*);

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_uniform_descending_max_core verification failed");
            $finish;
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 6);
    end

    // one sample beat, with random gaps ahead of it
    task automatic send_sample(input logic [31:0] u);
        while (!no_idle && $urandom_range(99) < 6) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_uniform_sample = u;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold off until all results are back and the engine has settled
    task automatic drain;
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_run_length(input logic [31:0] len);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = RUN_LENGTH_ADDR;
        pwdata = len;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic logic [31:0] random_sample;
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            2: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        int burst;
        int phase;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes under the reset run length
        send_sample(32'd0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd1);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFE);
        // single-value runs, then zero length treated as one
        write_run_length(32'd1);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd0);
        send_sample(32'h5555_5555);
        write_run_length(32'd0);
        send_sample(32'hAAAA_AAAA);
        send_sample(32'd0);
        // oversize length saturates, then the largest legal one
        write_run_length(32'h001F_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        send_sample(32'hC000_0000);
        write_run_length(32'd1048576);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd0);
        // short runs that wrap several times
        write_run_length(32'd3);
        for (int k = 0; k < 7; k++) send_sample(32'hFFFF_FFFF - k);

        // random phases, mostly short runs
        sent = 0;
        phase = 0;
        while (sent < 900) begin
            case ($urandom_range(9))
                0: len = 1;
                1: len = $urandom_range(1048576, 2097151);
                2: len = $urandom_range(41, 4000);
                default: len = $urandom_range(2, 40);
            endcase
            write_run_length(len);
            no_idle = (phase == 4);
            burst = (len <= 40) ? len * $urandom_range(1, 3) : $urandom_range(5, 25);
            // long stretch without idling on either side
            if (phase == 4) burst = 150;
            for (int k = 0; k < burst; k++) begin
                send_sample(random_sample());
                sent++;
                // pause mid-phase until every result is back
                if (phase == 2 && k == burst / 2) drain();
            end
            phase++;
        end
        no_idle = 1'b0;

        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("sorted_uniform_descending_max_core verification clean");
        end else begin
            $display("sorted_uniform_descending_max_core verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
